// ===== hdl/packed_palette_rle_unpacker_assert.svh =====
// Assertion macros used by the packed palette unpacker back end.
// Expects clk and rst_n in the scope of the module that expands them.
`ifndef PACKED_PALETTE_RLE_UNPACKER_ASSERT_SVH
`define PACKED_PALETTE_RLE_UNPACKER_ASSERT_SVH

// same-cycle implication
`define PPRLE_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pprle assertion failed");

// next-cycle implication
`define PPRLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pprle assertion failed");

`endif

// ===== hdl/pprle_pkg.sv =====
// Shared types and constants for the packed palette unpacker.
// No dependencies.
`default_nettype none

package pprle_pkg;

    localparam int PALETTE_ENTRIES_DEFAULT = 256;
    localparam int RUNS_PER_BYTE           = 8;
    localparam int QUEUE_DEPTH             = 2;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 4;

    localparam logic [CFG_INDEX_W-1:0] CFG_BITS_PER_INDEX = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RLE_ENABLE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_EXPAND_RGBA    = 2'd2;

    localparam logic CMD_DATA          = 1'b0;
    localparam logic CMD_PALETTE_WRITE = 1'b1;

    localparam logic [3:0] BITS_PER_INDEX_RESET = 4'd8;
    localparam logic [3:0] MAX_DEPTH            = 4'd8;
    localparam logic [3:0] COUNT_BITS           = 4'd8;

    typedef enum logic [1:0] {
        PH_FLAG  = 2'd0,
        PH_COUNT = 2'd1,
        PH_VALUE = 2'd2
    } phase_t;

    typedef struct packed {
        logic        cmd;
        logic [7:0]  data_byte;
        logic [7:0]  entry_index;
        logic [31:0] entry_color;
    } in_word_t;

    typedef struct packed {
        logic [7:0]  color_index;
        logic [8:0]  run_length;
        logic [31:0] pixel_rgba;
        logic        last_of_item;
    } out_word_t;

    typedef struct packed {
        logic [7:0] idx;
        logic [8:0] len;
    } run_t;

    // one queue entry: either a palette write or the runs of one byte
    typedef struct packed {
        logic                          is_write;
        logic                          rgba;
        logic [3:0]                    count;
        run_t [RUNS_PER_BYTE-1:0]      runs;
        logic [7:0]                    widx;
        logic [31:0]                   wcolor;
    } bundle_t;

endpackage

`default_nettype wire

// ===== hdl/pprle_front.sv =====
// Front end: config registers, bit parser, bundles the runs of one byte or a palette write.
// Depends on pprle_pkg.
`default_nettype none

module pprle_front (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_stall,
    input  wire pprle_pkg::in_word_t                   in_data,
    input  wire logic                                  cfg_we,
    input  wire logic [pprle_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  wire logic [pprle_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                  q_full,
    output logic                                       q_push,
    output pprle_pkg::bundle_t                         q_wdata
);

    logic [3:0]        bpi_reg;
    logic              rle_en_reg;
    logic              rgba_reg;

    pprle_pkg::phase_t phase_reg, phase_next;
    logic [3:0]        cnt_reg, cnt_next;
    logic [7:0]        vs_reg, vs_next;
    logic [7:0]        rs_reg, rs_next;

    logic              accept;
    logic              is_palette;
    logic              rle;
    logic [3:0]        depth;
    logic [3:0]        n_runs;
    pprle_pkg::run_t [pprle_pkg::RUNS_PER_BYTE-1:0] runs;

    assign in_stall   = q_full;
    assign accept     = in_valid && !q_full;
    assign is_palette = (in_data.cmd == pprle_pkg::CMD_PALETTE_WRITE);
    assign rle        = rle_en_reg && !rgba_reg;

    always_comb
    begin
        priority if (bpi_reg == 4'd0)
            depth = 4'd1;
        else if (bpi_reg > pprle_pkg::MAX_DEPTH)
            depth = pprle_pkg::MAX_DEPTH;
        else
            depth = bpi_reg;
    end

    // walk the 8 bits MSB first
    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        vs_next    = vs_reg;
        rs_next    = rs_reg;
        n_runs     = 4'd0;
        runs       = '0;
        for (int j = 0; j < 8; j++)
        begin
            priority if (rle && phase_next == pprle_pkg::PH_FLAG)
            begin
                phase_next = in_data.data_byte[7-j] ? pprle_pkg::PH_COUNT
                                                    : pprle_pkg::PH_VALUE;
            end
            else if (rle && phase_next == pprle_pkg::PH_COUNT)
            begin
                rs_next  = {rs_next[6:0], in_data.data_byte[7-j]};
                cnt_next = cnt_next + 4'd1;
                if (cnt_next >= pprle_pkg::COUNT_BITS)
                begin
                    phase_next = pprle_pkg::PH_VALUE;
                    cnt_next   = 4'd0;
                end
            end
            else
            begin
                vs_next  = {vs_next[6:0], in_data.data_byte[7-j]};
                cnt_next = cnt_next + 4'd1;
                if (cnt_next >= depth)
                begin
                    runs[n_runs[2:0]].idx = vs_next;
                    if (rle)
                    begin
                        runs[n_runs[2:0]].len = {1'b0, rs_next} + 9'd1;
                        rs_next    = 8'd0;
                        phase_next = pprle_pkg::PH_FLAG;
                    end
                    else
                    begin
                        runs[n_runs[2:0]].len = 9'd1;
                    end
                    n_runs   = n_runs + 4'd1;
                    vs_next  = 8'd0;
                    cnt_next = 4'd0;
                end
            end
        end
    end

    always_comb
    begin
        q_wdata          = '0;
        q_wdata.is_write = is_palette;
        q_wdata.rgba     = rgba_reg;
        q_wdata.count    = n_runs;
        q_wdata.runs     = runs;
        q_wdata.widx     = in_data.entry_index;
        q_wdata.wcolor   = in_data.entry_color;
        q_push           = accept && (is_palette || n_runs != 4'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpi_reg    <= pprle_pkg::BITS_PER_INDEX_RESET;
            rle_en_reg <= 1'b0;
            rgba_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pprle_pkg::CFG_BITS_PER_INDEX: bpi_reg    <= cfg_data;
                pprle_pkg::CFG_RLE_ENABLE:     rle_en_reg <= cfg_data[0];
                pprle_pkg::CFG_EXPAND_RGBA:    rgba_reg   <= cfg_data[0];
                default:                       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= pprle_pkg::PH_FLAG;
            cnt_reg   <= 4'd0;
            vs_reg    <= 8'd0;
            rs_reg    <= 8'd0;
        end
        else if (accept && !is_palette)
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            vs_reg    <= vs_next;
            rs_reg    <= rs_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/pprle_queue.sv =====
// Short FIFO of bundles between front and back.
// Depends on pprle_pkg.
`default_nettype none

module pprle_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire pprle_pkg::bundle_t wdata,
    output logic                    full,
    input  wire logic               pop,
    output logic                    valid,
    output pprle_pkg::bundle_t      rdata
);

    localparam int DEPTH = pprle_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    pprle_pkg::bundle_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] cnt_reg, cnt_next;

    assign full  = (cnt_reg == CW'(DEPTH));
    assign valid = (cnt_reg != '0);
    assign rdata = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wdata;
    end

endmodule

`default_nettype wire

// ===== hdl/pprle_back.sv =====
// Back end: palette RAM, one run per cycle to the output register unless stalled.
// Depends on pprle_pkg and packed_palette_rle_unpacker_assert.svh.
`default_nettype none
`include "packed_palette_rle_unpacker_assert.svh"

module pprle_back #(
    parameter int PALETTE_ENTRIES = pprle_pkg::PALETTE_ENTRIES_DEFAULT
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire pprle_pkg::bundle_t q_rdata,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output pprle_pkg::out_word_t    out_data
);

    localparam int AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

    logic [31:0]   palette_mem [PALETTE_ENTRIES];

    logic [2:0]    pos_reg, pos_next;
    logic          ov_reg, ov_next;
    logic [7:0]    oidx_reg;
    logic [8:0]    olen_reg;
    logic          olast_reg;
    logic          ouse_reg;
    logic [31:0]   rd_reg;

    pprle_pkg::run_t cur_run;
    logic          advance;
    logic          write_fire;
    logic          read_fire;
    logic          run_last;
    logic          widx_ok;
    logic          ridx_ok;
    logic [3:0]    pos_ext;

    assign cur_run    = q_rdata.runs[pos_reg];
    assign pos_ext    = {1'b0, pos_reg};
    assign advance    = !ov_reg || !out_stall;
    assign write_fire = q_valid && q_rdata.is_write;
    assign read_fire  = q_valid && !q_rdata.is_write && advance;
    assign run_last   = (pos_ext + 4'd1 == q_rdata.count);
    assign widx_ok    = ({1'b0, q_rdata.widx} < 9'(PALETTE_ENTRIES));
    assign ridx_ok    = ({1'b0, cur_run.idx} < 9'(PALETTE_ENTRIES));
    assign q_pop      = write_fire || (read_fire && run_last);

    always_comb
    begin
        pos_next = pos_reg;
        if (read_fire)
            pos_next = run_last ? 3'd0 : pos_reg + 3'd1;
    end

    always_comb
    begin
        priority if (read_fire)
            ov_next = 1'b1;
        else if (!out_stall)
            ov_next = 1'b0;
        else
            ov_next = ov_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 3'd0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (read_fire)
        begin
            oidx_reg  <= cur_run.idx;
            olen_reg  <= cur_run.len;
            olast_reg <= run_last;
            ouse_reg  <= q_rdata.rgba && ridx_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (write_fire && widx_ok)
            palette_mem[q_rdata.widx[AW-1:0]] <= q_rdata.wcolor;
        if (read_fire)
            rd_reg <= palette_mem[cur_run.idx[AW-1:0]];
    end

    assign out_valid             = ov_reg;
    assign out_data.color_index  = oidx_reg;
    assign out_data.run_length   = olen_reg;
    assign out_data.pixel_rgba   = ouse_reg ? rd_reg : 32'd0;
    assign out_data.last_of_item = olast_reg;

    `PPRLE_ASSERT_NEXT(a_pos_step, read_fire && !run_last, pos_reg == $past(pos_reg) + 3'd1)
    `PPRLE_ASSERT_IMPL(a_pos_in_bundle, q_valid && !q_rdata.is_write, pos_ext < q_rdata.count)
    `PPRLE_ASSERT_IMPL(a_pop_has_head, q_pop, q_valid)
    `PPRLE_ASSERT_IMPL(a_run_nonzero, ov_reg, olen_reg != 9'd0)

endmodule

`default_nettype wire

// ===== hdl/packed_palette_rle_unpacker.sv =====
// Packed palette index unpacker with optional run-length format, top level.
// Depends on pprle_pkg, pprle_front, pprle_queue, pprle_back.
//
// Input words (in_valid/in_stall/in_data) are packed image bytes (cmd 0) or
// palette entry writes (cmd 1). Output words (out_valid/out_stall/out_data)
// are runs: palette index, run length, RGBA color in expand mode, and a last
// flag on the final run of a byte. The config port (cfg_we, cfg_index,
// cfg_data) writes bits_per_index, rle_enable, expand_rgba; write only idle.
// The runs of an accepted byte pass through the bundle queue and then the
// output register before out_valid rises.
// Throughput: one input word per cycle while in_stall is low; the back end
// issues one run or one palette write per cycle; runs wait while out_stall is high.
// A 2-entry bundle queue lets the front keep taking bytes while runs drain.
// Output stall freezes the output register; the queue then fills and
// in_stall rises. Reset clears parser state, queue and config to defaults;
// palette contents are undefined until written.
`default_nettype none

module packed_palette_rle_unpacker #(
    parameter int PALETTE_ENTRIES = pprle_pkg::PALETTE_ENTRIES_DEFAULT
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire pprle_pkg::in_word_t               in_data,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output pprle_pkg::out_word_t                   out_data,
    input  wire logic                              cfg_we,
    input  wire logic [pprle_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pprle_pkg::CFG_DATA_W-1:0]  cfg_data
);

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_valid;
    pprle_pkg::bundle_t q_wdata;
    pprle_pkg::bundle_t q_rdata;

    pprle_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_wdata   (q_wdata)
    );

    pprle_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .valid (q_valid),
        .rdata (q_rdata)
    );

    pprle_back #(
        .PALETTE_ENTRIES (PALETTE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire

// ===== tb/sv/packed_palette_rle_unpacker_tb.sv =====
// Self-checking testbench for packed_palette_rle_unpacker: directed and random words,
// predicted runs checked in order against the output channel.
// Depends on pprle_pkg and the packed_palette_rle_unpacker RTL.
`default_nettype none

module packed_palette_rle_unpacker_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 300000;
    localparam int MAX_PRINTS  = 50;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    pprle_pkg::in_word_t  in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    pprle_pkg::out_word_t out_data;
    logic                 cfg_we = 1'b0;
    logic [pprle_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [pprle_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor state
    logic [3:0]        cfg_depth = pprle_pkg::BITS_PER_INDEX_RESET;
    logic              cfg_rle = 1'b0;
    logic              cfg_rgba = 1'b0;
    pprle_pkg::phase_t parse_ph = pprle_pkg::PH_FLAG;
    logic [3:0]        bit_cnt = '0;
    logic [7:0]        value_acc = '0;
    logic [7:0]        repeat_acc = '0;
    logic [31:0]       palette_copy [pprle_pkg::PALETTE_ENTRIES_DEFAULT];

    pprle_pkg::out_word_t pending_runs[$];
    int        mismatch_cnt = 0;
    int        cycle_cnt = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;

    packed_palette_rle_unpacker DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("packed_palette_rle_unpacker_tb: FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_cnt < MAX_PRINTS)
            $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    always @(posedge clk)
    begin : check_runs
        pprle_pkg::out_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_runs.size() == 0)
                report_mismatch("unexpected run", out_data.color_index, 32'd0);
            else
            begin
                want = pending_runs.pop_front();
                if (out_data.color_index !== want.color_index)
                    report_mismatch("color_index", out_data.color_index, want.color_index);
                if (out_data.run_length !== want.run_length)
                    report_mismatch("run_length", out_data.run_length, want.run_length);
                if (out_data.pixel_rgba !== want.pixel_rgba)
                    report_mismatch("pixel_rgba", out_data.pixel_rgba, want.pixel_rgba);
                if (out_data.last_of_item !== want.last_of_item)
                    report_mismatch("last_of_item", out_data.last_of_item,
                                    want.last_of_item);
            end
        end
        out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
    end

    // decode one accepted word into the runs it yields
    task automatic predict_runs(input pprle_pkg::in_word_t w);
        logic [3:0]           depth;
        logic                 rle;
        logic                 b;
        pprle_pkg::out_word_t r;
        pprle_pkg::out_word_t runs[$];
        if (w.cmd == pprle_pkg::CMD_PALETTE_WRITE)
        begin
            palette_copy[w.entry_index] = w.entry_color;
            return;
        end
        if (cfg_depth == 4'd0)
            depth = 4'd1;
        else if (cfg_depth > pprle_pkg::MAX_DEPTH)
            depth = pprle_pkg::MAX_DEPTH;
        else
            depth = cfg_depth;
        rle = cfg_rle && !cfg_rgba;
        for (int j = 7; j >= 0; j--)
        begin
            b = w.data_byte[j];
            if (rle && parse_ph == pprle_pkg::PH_FLAG)
            begin
                if (b)
                    parse_ph = pprle_pkg::PH_COUNT;
                else
                    parse_ph = pprle_pkg::PH_VALUE;
            end
            else if (rle && parse_ph == pprle_pkg::PH_COUNT)
            begin
                repeat_acc = {repeat_acc[6:0], b};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= pprle_pkg::COUNT_BITS)
                begin
                    parse_ph = pprle_pkg::PH_VALUE;
                    bit_cnt = '0;
                end
            end
            else
            begin
                value_acc = {value_acc[6:0], b};
                bit_cnt = bit_cnt + 4'd1;
                if (bit_cnt >= depth)
                begin
                    r.color_index = value_acc;
                    r.run_length = 9'd1;
                    r.pixel_rgba = '0;
                    r.last_of_item = 1'b0;
                    if (rle)
                    begin
                        r.run_length = {1'b0, repeat_acc} + 9'd1;
                        repeat_acc = '0;
                        parse_ph = pprle_pkg::PH_FLAG;
                    end
                    else if (cfg_rgba)
                        r.pixel_rgba = palette_copy[value_acc];
                    runs.insert(runs.size(), r);
                    value_acc = '0;
                    bit_cnt = '0;
                end
            end
        end
        if (runs.size() != 0)
            runs[runs.size() - 1].last_of_item = 1'b1;
        foreach (runs[k])
            pending_runs.insert(pending_runs.size(), runs[k]);
    endtask

    task automatic send_word(input pprle_pkg::in_word_t w);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_runs(w);
    endtask

    task automatic send_data(input logic [7:0] b);
        pprle_pkg::in_word_t w;
        w.cmd = pprle_pkg::CMD_DATA;
        w.data_byte = b;
        w.entry_index = 8'($urandom);
        w.entry_color = $urandom;
        send_word(w);
    endtask

    task automatic send_palette(input logic [7:0] idx, input logic [31:0] color);
        pprle_pkg::in_word_t w;
        w.cmd = pprle_pkg::CMD_PALETTE_WRITE;
        w.data_byte = 8'($urandom);
        w.entry_index = idx;
        w.entry_color = color;
        send_word(w);
    endtask

    task automatic drain(input int settle);
        in_valid <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // writes all three registers back to back; only called once drained
    task automatic set_config(input logic [3:0] depth, input logic rle, input logic rgba);
        drain(16);
        cfg_we <= 1'b1;
        cfg_index <= pprle_pkg::CFG_BITS_PER_INDEX;
        cfg_data <= depth;
        @(posedge clk);
        cfg_depth = depth;
        cfg_index <= pprle_pkg::CFG_RLE_ENABLE;
        cfg_data <= {3'b000, rle};
        @(posedge clk);
        cfg_rle = rle;
        cfg_index <= pprle_pkg::CFG_EXPAND_RGBA;
        cfg_data <= {3'b000, rgba};
        @(posedge clk);
        cfg_rgba = rgba;
        cfg_we <= 1'b0;
    endtask

    task automatic test_plain_depths();
        set_config(4'd8, 1'b0, 1'b0);
        send_data(8'h00);
        send_data(8'hFF);
        send_data(8'h5A);
        set_config(4'd1, 1'b0, 1'b0);
        send_data(8'hA5);
        set_config(4'd3, 1'b0, 1'b0);
        send_data(8'hC7);
        send_data(8'h3D);
        set_config(4'd5, 1'b0, 1'b0);
        send_data(8'h96);
        // depth lowered with bits still held
        set_config(4'd2, 1'b0, 1'b0);
        send_data(8'h0F);
        set_config(4'd0, 1'b0, 1'b0);
        send_data(8'h3C);
        set_config(4'd15, 1'b0, 1'b0);
        send_data(8'h81);
        set_config(4'd9, 1'b0, 1'b0);
        send_data(8'h7E);
    endtask

    task automatic test_rle_runs();
        set_config(4'd4, 1'b1, 1'b0);
        send_data(8'hFF);
        send_data(8'hFF);
        send_data(8'h00);
        send_data(8'h00);
        send_data(8'h2A);
        send_data(8'h80);
        set_config(4'd1, 1'b1, 1'b0);
        send_data(8'h6B);
        set_config(4'd8, 1'b1, 1'b0);
        send_data(8'hD2);
        send_data(8'h4F);
    endtask

    task automatic test_mode_switch();
        set_config(4'd4, 1'b1, 1'b0);
        send_data(8'hC3);
        set_config(4'd4, 1'b0, 1'b0);
        send_data(8'h5C);
        set_config(4'd4, 1'b1, 1'b0);
        send_data(8'h3E);
    endtask

    // every entry gets written before any lookup can happen
    task automatic test_palette_load();
        logic [7:0] order [pprle_pkg::PALETTE_ENTRIES_DEFAULT];
        int         k;
        logic [7:0] t;
        foreach (order[i])
            order[i] = 8'(i);
        for (int i = pprle_pkg::PALETTE_ENTRIES_DEFAULT - 1; i > 0; i--)
        begin
            k = $urandom_range(i);
            t = order[i];
            order[i] = order[k];
            order[k] = t;
        end
        foreach (order[i])
            send_palette(order[i], $urandom);
    endtask

    task automatic test_rgba_lookup();
        set_config(4'd8, 1'b1, 1'b1);
        send_data(8'h00);
        send_data(8'hFF);
        set_config(4'd1, 1'b0, 1'b1);
        send_data(8'hA5);
    endtask

    task automatic test_random(input int idle_pct, input int stall_level);
        logic [7:0] b;
        send_idle_pct = idle_pct;
        stall_pct = stall_level;
        for (int s = 0; s < 3; s++)
        begin
            set_config(4'($urandom_range(15)), 1'($urandom), 1'($urandom));
            for (int i = 0; i < 13; i++)
            begin
                if ($urandom_range(99) < 15)
                    send_palette(8'($urandom), $urandom);
                else
                begin
                    case ($urandom_range(9))
                        0: b = 8'h00;
                        1: b = 8'hFF;
                        default: b = 8'($urandom);
                    endcase
                    send_data(b);
                end
                if ($urandom_range(19) == 0)
                    drain(0);
            end
        end
    endtask

    initial
    begin
        foreach (palette_copy[i])
            palette_copy[i] = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_plain_depths();
        test_rle_runs();
        test_mode_switch();
        test_palette_load();
        test_rgba_lookup();
        test_random(0, 0);
        test_random(53, 0);
        test_random(0, 53);
        test_random(36, 36);
        drain(32);
        if (mismatch_cnt == 0 && pending_runs.size() == 0)
            $display("packed_palette_rle_unpacker_tb: PASS");
        else
            $display("packed_palette_rle_unpacker_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+hdl
hdl/pprle_pkg.sv
hdl/pprle_front.sv
hdl/pprle_queue.sv
hdl/pprle_back.sv
hdl/packed_palette_rle_unpacker.sv
tb/sv/packed_palette_rle_unpacker_tb.sv
